// File: src/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types and constants of the pressure-volume loop area block.
// ----------------------------------------------------------------------------
`default_nettype none

package pva_pkg;

  // Default parameter values
  localparam int SAMPLE_BITS    = 16;
  localparam int ACC_BITS       = 48;
  localparam int GAIN_FRAC_BITS = 16;

  // Fixed widths
  localparam int GAIN_W     = 16;
  localparam int OUT_W      = 48;
  localparam int CHUNK_W    = 32;  // magnitude digit fed to the multiplier per pass
  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_W  = 1;

  localparam logic [GAIN_W-1:0]    GAIN_RESET    = 16'h8000;
  localparam logic [CFG_IDX_W-1:0] REG_WORK_GAIN = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_EDGE,
    ST_ADD_EDGE,
    ST_MUL_CLOSE,
    ST_ADD_CLOSE,
    ST_MAG,
    ST_MUL_SCALE,
    ST_ADD_SCALE,
    ST_FINISH,
    ST_EMIT
  } pva_state_e;

  // Operand select of the shared multiplier
  typedef enum logic [1:0] {
    OP_EDGE,
    OP_CLOSE,
    OP_SCALE
  } pva_op_e;

  typedef struct packed {
    logic    ready;
    pva_op_e op;
    logic    mul_en;
    logic    acc_add;
    logic    adv_prev;
    logic    mag_load;
    logic    scale_add;
    logic    finish;
    logic    emit;
  } pva_ctrl_t;

endpackage

`default_nettype wire

// File: src/pva_mul.sv
// ----------------------------------------------------------------------------
// pva_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module pva_mul #(
  parameter int A_W = 33,
  parameter int B_W = 17
) (
  input  wire                        clk_i,
  input  wire                        en_i,
  input  wire  logic signed [A_W-1:0] a_i,
  input  wire  logic signed [B_W-1:0] b_i,
  output logic signed [A_W+B_W-1:0]  p_o
);

  logic signed [A_W+B_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= (A_W+B_W)'(a_i) * (A_W+B_W)'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// File: src/pva_cfg.sv
// ----------------------------------------------------------------------------
// pva_cfg
// APB register file: holds the work gain.
// ----------------------------------------------------------------------------
`default_nettype none

module pva_cfg (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [pva_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire  [pva_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [pva_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  output logic [pva_pkg::GAIN_W-1:0]          gain_o
);

  localparam int AddrW = pva_pkg::CFG_ADDR_W;

  logic [pva_pkg::GAIN_W-1:0]    gain_q, gain_d;
  logic [pva_pkg::CFG_IDX_W-1:0] idx;
  logic                          wr_en;

  assign idx    = paddr[AddrW-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    gain_d = gain_q;
    prdata = '0;
    unique case (idx)
      pva_pkg::REG_WORK_GAIN: begin
        prdata = pva_pkg::APB_DATA_W'(gain_q);
        if (wr_en) begin
          gain_d = pwdata[pva_pkg::GAIN_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= pva_pkg::GAIN_RESET;
    end else begin
      gain_q <= gain_d;
    end
  end

  assign gain_o = gain_q;

endmodule

`default_nettype wire

// File: src/pva_ctrl.sv
// ----------------------------------------------------------------------------
// pva_ctrl
// Sequencer: steps the shared multiplier and accumulator through one sample.
// ----------------------------------------------------------------------------
`default_nettype none

module pva_ctrl #(
  parameter int N_CHUNKS = 2
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_fire_i,
  input  wire                in_mark_i,   // mark of the word being accepted
  input  wire                mark_q_i,    // mark of the word in work
  input  wire                loop_open_i,
  input  wire                out_free_i,
  output pva_pkg::pva_ctrl_t ctrl_o
);

  localparam int CntW = (N_CHUNKS > 1) ? $clog2(N_CHUNKS) : 1;

  pva_pkg::pva_state_e state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                last_chunk;

  assign last_chunk = (cnt_q == CntW'(N_CHUNKS - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pva_pkg::ST_IDLE: begin
        if (in_fire_i) begin
          if (loop_open_i) begin
            state_d = pva_pkg::ST_MUL_EDGE;
          end else if (in_mark_i) begin
            state_d = pva_pkg::ST_EMIT;
          end
        end
      end
      pva_pkg::ST_MUL_EDGE:  state_d = pva_pkg::ST_ADD_EDGE;
      pva_pkg::ST_ADD_EDGE: begin
        state_d = mark_q_i ? pva_pkg::ST_MUL_CLOSE : pva_pkg::ST_IDLE;
      end
      pva_pkg::ST_MUL_CLOSE: state_d = pva_pkg::ST_ADD_CLOSE;
      pva_pkg::ST_ADD_CLOSE: state_d = pva_pkg::ST_MAG;
      pva_pkg::ST_MAG:       state_d = pva_pkg::ST_MUL_SCALE;
      pva_pkg::ST_MUL_SCALE: state_d = pva_pkg::ST_ADD_SCALE;
      pva_pkg::ST_ADD_SCALE: begin
        state_d = last_chunk ? pva_pkg::ST_FINISH : pva_pkg::ST_MUL_SCALE;
      end
      pva_pkg::ST_FINISH:    state_d = pva_pkg::ST_EMIT;
      pva_pkg::ST_EMIT: begin
        if (out_free_i) begin
          state_d = pva_pkg::ST_IDLE;
        end
      end
      default:               state_d = pva_pkg::ST_IDLE;
    endcase
  end

  // Chunk counter
  always_comb begin
    cnt_d = cnt_q;
    if (state_q == pva_pkg::ST_MAG) begin
      cnt_d = '0;
    end else if (state_q == pva_pkg::ST_ADD_SCALE) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // Outputs
  always_comb begin
    ctrl_o = '0;
    ctrl_o.op = pva_pkg::OP_EDGE;
    unique case (state_q)
      pva_pkg::ST_IDLE:      ctrl_o.ready = 1'b1;
      pva_pkg::ST_MUL_EDGE:  ctrl_o.mul_en = 1'b1;
      pva_pkg::ST_ADD_EDGE: begin
        ctrl_o.acc_add  = 1'b1;
        ctrl_o.adv_prev = 1'b1;
      end
      pva_pkg::ST_MUL_CLOSE: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.op     = pva_pkg::OP_CLOSE;
      end
      pva_pkg::ST_ADD_CLOSE: ctrl_o.acc_add = 1'b1;
      pva_pkg::ST_MAG:       ctrl_o.mag_load = 1'b1;
      pva_pkg::ST_MUL_SCALE: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.op     = pva_pkg::OP_SCALE;
      end
      pva_pkg::ST_ADD_SCALE: ctrl_o.scale_add = 1'b1;
      pva_pkg::ST_FINISH:    ctrl_o.finish = 1'b1;
      pva_pkg::ST_EMIT:      ctrl_o.emit = out_free_i;
      default:               ctrl_o.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pva_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: src/pressure_volume_loop_area.sv
// ----------------------------------------------------------------------------
// pressure_volume_loop_area
// Shoelace area of pressure-volume loops, scaled by a programmable gain.
// ----------------------------------------------------------------------------
// Each input word is one pressure/volume sample; tlast marks a beat. A beat
// closes the open loop (adding its own edge and the edge back to the loop's
// first vertex), scales the doubled area by work_gain (Q GAIN_FRAC_BITS), and
// returns one word: stroke_work, work_valid, saturated. The beat sample then
// opens the next loop. A beat with no loop open returns a word with all
// fields zero; samples before the first beat are dropped without a result.
// Operation: the block takes one word at a time and runs it through a single
// shared multiplier. A plain sample inside a loop is accepted, multiplied and
// added; a sample before the first beat is only accepted; a beat with no loop
// open is accepted and then loaded into the output; a beat that closes a loop
// computes its own edge term and the closing edge term, then the 32-bit digits
// of |area| times the gain, then the final clamp and the output load.
// A finished word waits in the output register, and the sequencer holds in
// its last step only when that register is still full.
// The accumulator clamps to the signed ACC_BITS range; saturated reports a
// clamp of the sum in this loop or of the scaled result. work_gain sits at
// APB byte address 0 (reset 0x8000); the user must write it only while
// idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_volume_loop_area #(
  parameter int SAMPLE_BITS    = pva_pkg::SAMPLE_BITS,
  parameter int ACC_BITS       = pva_pkg::ACC_BITS,
  parameter int GAIN_FRAC_BITS = pva_pkg::GAIN_FRAC_BITS
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // stream in
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: pressure [SAMPLE_BITS-1:0], volume [2*SAMPLE_BITS-1:SAMPLE_BITS]
  input  wire  [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  wire                                s_axis_tlast,   // beat_mark
  // stream out
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // tdata: stroke_work [47:0]
  output logic [pva_pkg::OUT_W-1:0]          m_axis_tdata,
  // tuser: work_valid [0], saturated [1]
  output logic [1:0]                         m_axis_tuser,
  // config
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [pva_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire  [pva_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [pva_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int SB     = SAMPLE_BITS;
  localparam int AccW   = ACC_BITS;
  localparam int ChunkW = pva_pkg::CHUNK_W;
  localparam int GainW  = pva_pkg::GAIN_W;
  localparam int OutW   = pva_pkg::OUT_W;
  localparam int MulAW  = ChunkW + 1;
  localparam int MulBW  = (SB + 1 > GainW + 1) ? SB + 1 : GainW + 1;
  localparam int MulPW  = MulAW + MulBW;
  localparam int SumW   = ((AccW > MulPW) ? AccW : MulPW) + 1;
  localparam int NChunk = (AccW + ChunkW - 1) / ChunkW;
  localparam int MagW   = NChunk * ChunkW;
  localparam int WideW  = MagW + GainW;

  localparam logic signed [SumW-1:0] SumMax = {{(SumW-AccW+1){1'b0}}, {(AccW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {{(SumW-AccW+1){1'b1}}, {(AccW-1){1'b0}}};
  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
  localparam logic [WideW-1:0]       LimPos = WideW'({(AccW-1){1'b1}});
  localparam logic [WideW-1:0]       LimNeg = WideW'(1) << (AccW - 1);

  pva_pkg::pva_ctrl_t ctrl;
  logic [GainW-1:0]   gain;
  logic               in_fire, out_free;

  // sample registers
  logic signed [SB-1:0] cur_p_q, cur_p_d, first_p_q, first_p_d, prev_p_q, prev_p_d;
  logic [SB-1:0]        cur_v_q, cur_v_d, first_v_q, first_v_d, prev_v_q, prev_v_d;
  logic                 mark_q, mark_d;
  logic                 loop_open_q, loop_open_d;

  // accumulator
  logic signed [AccW-1:0] acc_q, acc_d;
  logic                   sum_sat_q, sum_sat_d;
  logic signed [SumW-1:0] sum_ext;
  logic signed [AccW-1:0] acc_clamp;
  logic                   acc_ovf;

  // scaling
  logic [MagW-1:0]        mag_q, mag_d;
  logic                   neg_q, neg_d;
  logic [AccW-1:0]        mag_abs;
  logic [WideW-1:0]       wide_q, wide_d;
  logic [WideW-1:0]       q_full, lim;
  logic                   osat;
  logic [AccW-1:0]        q_mag;
  logic signed [AccW-1:0] res_s;

  // result and output registers
  logic [OutW-1:0] res_work_q, res_work_d, m_work_q, m_work_d;
  logic            res_valid_q, res_valid_d, res_sat_q, res_sat_d;
  logic [1:0]      m_flags_q, m_flags_d;
  logic            m_valid_q, m_valid_d;

  // shared multiplier operands
  logic signed [SB:0]        psum_e, psum_c, vdif_e, vdif_c;
  logic signed [MulAW-1:0]   mul_a;
  logic signed [MulBW-1:0]   mul_b;
  logic signed [MulPW-1:0]   prod;
  logic [MulPW-1:0]          prod_u;

  pva_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gain_o  (gain)
  );

  assign in_fire  = s_axis_tvalid && ctrl.ready;
  assign out_free = !m_valid_q || m_axis_tready;

  pva_ctrl #(
    .N_CHUNKS (NChunk)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .in_mark_i   (s_axis_tlast),
    .mark_q_i    (mark_q),
    .loop_open_i (loop_open_q),
    .out_free_i  (out_free),
    .ctrl_o      (ctrl)
  );

  // Operand select: edge term, closing term, or one magnitude digit x gain
  always_comb begin
    psum_e = {prev_p_q[SB-1], prev_p_q} + {cur_p_q[SB-1], cur_p_q};
    vdif_e = {1'b0, prev_v_q} - {1'b0, cur_v_q};
    psum_c = {cur_p_q[SB-1], cur_p_q} + {first_p_q[SB-1], first_p_q};
    vdif_c = {1'b0, cur_v_q} - {1'b0, first_v_q};
    case (ctrl.op)
      pva_pkg::OP_EDGE: begin
        mul_a = MulAW'(psum_e);
        mul_b = MulBW'(vdif_e);
      end
      pva_pkg::OP_SCALE: begin
        mul_a = MulAW'(mag_q[MagW-1 -: ChunkW]);
        mul_b = MulBW'(gain);
      end
      default: begin
        mul_a = MulAW'(psum_c);
        mul_b = MulBW'(vdif_c);
      end
    endcase
  end

  pva_mul #(
    .A_W (MulAW),
    .B_W (MulBW)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (ctrl.mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign prod_u = prod;

  // Saturating accumulate of one shoelace term
  always_comb begin
    sum_ext = SumW'(acc_q) + SumW'(prod);
    acc_ovf = 1'b0;
    if (sum_ext > SumMax) begin
      acc_clamp = AccMax;
      acc_ovf   = 1'b1;
    end else if (sum_ext < SumMin) begin
      acc_clamp = AccMin;
      acc_ovf   = 1'b1;
    end else begin
      acc_clamp = sum_ext[AccW-1:0];
    end
  end

  // Scaled result: truncate toward zero, clamp to the signed range
  always_comb begin
    mag_abs = acc_q[AccW-1] ? (~acc_q + 1'b1) : acc_q;
    q_full  = wide_q >> GAIN_FRAC_BITS;
    lim     = neg_q ? LimNeg : LimPos;
    osat    = q_full > lim;
    q_mag   = osat ? lim[AccW-1:0] : q_full[AccW-1:0];
    res_s   = neg_q ? -q_mag : q_mag;
  end

  always_comb begin
    cur_p_d     = cur_p_q;
    cur_v_d     = cur_v_q;
    mark_d      = mark_q;
    first_p_d   = first_p_q;
    first_v_d   = first_v_q;
    prev_p_d    = prev_p_q;
    prev_v_d    = prev_v_q;
    loop_open_d = loop_open_q;
    acc_d       = acc_q;
    sum_sat_d   = sum_sat_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    wide_d      = wide_q;
    res_work_d  = res_work_q;
    res_valid_d = res_valid_q;
    res_sat_d   = res_sat_q;
    m_work_d    = m_work_q;
    m_flags_d   = m_flags_q;
    m_valid_d   = m_valid_q;

    if (in_fire) begin
      cur_p_d     = s_axis_tdata[SB-1:0];
      cur_v_d     = s_axis_tdata[2*SB-1:SB];
      mark_d      = s_axis_tlast;
      res_work_d  = '0;   // beat with no open loop reports all zero
      res_valid_d = 1'b0;
      res_sat_d   = 1'b0;
    end
    if (ctrl.acc_add) begin
      acc_d     = acc_clamp;
      sum_sat_d = sum_sat_q || acc_ovf;
    end
    if (ctrl.adv_prev) begin
      prev_p_d = cur_p_q;
      prev_v_d = cur_v_q;
    end
    if (ctrl.mag_load) begin
      neg_d  = acc_q[AccW-1];
      mag_d  = MagW'(mag_abs);
      wide_d = '0;
    end
    if (ctrl.scale_add) begin
      // most significant digit first
      wide_d = (wide_q << ChunkW) + WideW'(prod_u);
      mag_d  = mag_q << ChunkW;
    end
    if (ctrl.finish) begin
      res_work_d  = OutW'(res_s);
      res_valid_d = 1'b1;
      res_sat_d   = sum_sat_q || osat;
    end

    if (ctrl.emit) begin
      m_work_d    = res_work_q;
      m_flags_d   = {res_sat_q, res_valid_q};
      m_valid_d   = 1'b1;
      // the beat sample opens the next loop
      loop_open_d = 1'b1;
      first_p_d   = cur_p_q;
      first_v_d   = cur_v_q;
      prev_p_d    = cur_p_q;
      prev_v_d    = cur_v_q;
      acc_d       = '0;
      sum_sat_d   = 1'b0;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_open_q <= 1'b0;
      acc_q       <= '0;
      sum_sat_q   <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      loop_open_q <= loop_open_d;
      acc_q       <= acc_d;
      sum_sat_q   <= sum_sat_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_p_q     <= cur_p_d;
    cur_v_q     <= cur_v_d;
    mark_q      <= mark_d;
    first_p_q   <= first_p_d;
    first_v_q   <= first_v_d;
    prev_p_q    <= prev_p_d;
    prev_v_q    <= prev_v_d;
    mag_q       <= mag_d;
    neg_q       <= neg_d;
    wide_q      <= wide_d;
    res_work_q  <= res_work_d;
    res_valid_q <= res_valid_d;
    res_sat_q   <= res_sat_d;
    m_work_q    <= m_work_d;
    m_flags_q   <= m_flags_d;
  end

  assign s_axis_tready = ctrl.ready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_work_q;
  assign m_axis_tuser  = m_flags_q;

  // A word leaving the sequencer lands in the output register
  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |=> m_axis_tvalid)
    else $error("emitted word did not reach output register");

  // An invalid loop reports zero work and no saturation
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> ((m_axis_tdata == '0) && !m_axis_tuser[1]))
    else $error("invalid result carries nonzero fields");

  // A sample inside an open loop keeps the block busy
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && loop_open_q) |=> !s_axis_tready)
    else $error("took a word while the shared unit was in use");

  // Closing a loop restarts the accumulator
  a_loop_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |=> (loop_open_q && (acc_q == '0) && !sum_sat_q))
    else $error("loop not restarted after beat");

endmodule

`default_nettype wire

// File: sim/loop_area_board_pkg.sv
// ----------------------------------------------------------------------------
// loop_area_board_pkg
// Scoreboard for the pressure-volume loop area block: keeps its own copy of
// the loop state and gain, predicts the word each beat returns, and checks
// returned words in order.
// ----------------------------------------------------------------------------
package loop_area_board_pkg;

  import pva_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] work;
    logic             valid;
    logic             sat;
  } work_word_t;

  class loop_area_board;

    localparam longint ACC_HI = (64'sd1 <<< (ACC_BITS - 1)) - 1;
    localparam longint ACC_LO = -ACC_HI - 1;

    logic [GAIN_W-1:0] gain = GAIN_RESET;
    bit                loop_open;
    longint            first_p, first_v, prev_p, prev_v;
    longint            area_sum;
    bit                sum_sat;
    work_word_t        work_q[$];
    int                errors;

    task report(string msg);
      $display("tb: mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function int pending();
      return work_q.size();
    endfunction

    function longint edge_term(longint pa, longint va, longint pb, longint vb);
      return (pa + pb) * (va - vb);
    endfunction

    // clamping accumulate, sticky flag until the loop closes
    function void add_term(longint term);
      if (term > 0 && area_sum > ACC_HI - term) begin
        area_sum = ACC_HI;
        sum_sat  = 1'b1;
      end else if (term < 0 && area_sum < ACC_LO - term) begin
        area_sum = ACC_LO;
        sum_sat  = 1'b1;
      end else begin
        area_sum += term;
      end
    endfunction

    // |sum| * gain >> frac, truncating toward zero, clamped to the acc range
    function longint scaled_work(longint s, output bit sat);
      longint unsigned mag, lim, a, b, q;
      bit              neg;
      neg = s < 0;
      mag = neg ? -s : s;
      lim = neg ? longint'(ACC_HI) + 1 : longint'(ACC_HI);
      a   = (mag >> CHUNK_W) * gain;
      b   = (mag & 64'hFFFF_FFFF) * gain;
      sat = 1'b0;
      if (a > (lim >> (CHUNK_W - GAIN_FRAC_BITS))) begin
        q   = lim;
        sat = 1'b1;
      end else begin
        q = (a << (CHUNK_W - GAIN_FRAC_BITS)) + (b >> GAIN_FRAC_BITS);
        if (q > lim) begin
          q   = lim;
          sat = 1'b1;
        end
      end
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function void note_sample(logic signed [SAMPLE_BITS-1:0] p,
                              logic [SAMPLE_BITS-1:0] v, bit mark);
      longint ps, vs, w;
      bit     osat;
      ps = p;
      vs = v;
      if (!mark) begin
        if (loop_open) begin
          add_term(edge_term(prev_p, prev_v, ps, vs));
          prev_p = ps;
          prev_v = vs;
        end
        return;
      end
      if (loop_open) begin
        add_term(edge_term(prev_p, prev_v, ps, vs));
        add_term(edge_term(ps, vs, first_p, first_v));
        w = scaled_work(area_sum, osat);
        work_q.push_back('{work: w[OUT_W-1:0], valid: 1'b1, sat: sum_sat | osat});
      end else begin
        work_q.push_back('{work: '0, valid: 1'b0, sat: 1'b0});
      end
      loop_open = 1'b1;
      first_p   = ps;
      prev_p    = ps;
      first_v   = vs;
      prev_v    = vs;
      area_sum  = 0;
      sum_sat   = 1'b0;
    endfunction

    task check_word(logic [OUT_W-1:0] data, logic [1:0] user);
      work_word_t exp_w;
      if (work_q.size() == 0) begin
        report($sformatf("unexpected word work=%0h user=%0b", data, user));
        return;
      end
      exp_w = work_q.pop_front();
      if (data !== exp_w.work)
        report($sformatf("stroke_work %0h, want %0h", data, exp_w.work));
      if (user[0] !== exp_w.valid)
        report($sformatf("work_valid %0b, want %0b", user[0], exp_w.valid));
      if (user[1] !== exp_w.sat)
        report($sformatf("saturated %0b, want %0b", user[1], exp_w.sat));
    endtask

  endclass

endpackage

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the pressure-volume loop area block. Samples go in
// with random gaps, words come out against random back-pressure, and each
// word is checked against a scoreboard that tracks loop state and gain.
// Runs a short directed set, two box windings that build large positive
// and negative areas, then random loops under several gains.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import pva_pkg::*;
  import loop_area_board_pkg::*;

  localparam int DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  // register map: byte address 4*index; index one holds no register
  localparam logic [CFG_ADDR_W-1:0] ADDR_WORK_GAIN = CFG_ADDR_W'(REG_WORK_GAIN) << 2;
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE     = CFG_ADDR_W'(4);

  // a closing beat or a plain sample finishes well within this; leave margin
  localparam int SETTLE_CYCLES = 16;
  // longest quiet stretch is a drain plus two register accesses, well under this
  localparam int STALL_LIMIT   = 1000;
  // one winding round adds about 2^33, giving areas near 2^37
  localparam int WIND_ROUNDS   = 25;
  localparam int PHASE_WORDS   = 130;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [DATA_W-1:0]      s_axis_tdata  = '0;  // pressure [15:0], volume [31:16]
  logic                   s_axis_tlast  = 1'b0; // beat mark
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_W-1:0]       m_axis_tdata;        // stroke_work [47:0]
  logic [1:0]             m_axis_tuser;        // work_valid [0], saturated [1]
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [CFG_ADDR_W-1:0]  paddr         = '0;
  logic [APB_DATA_W-1:0]  pwdata        = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  int idle_pct = 13;   // per-cycle idle chance of both sides, in percent
  int quiet_cycles;

  loop_area_board board = new();

  pressure_volume_loop_area u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  // Output side: random back-pressure, one update per edge.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  // Every word taken at an edge goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_word(m_axis_tdata, m_axis_tuser);
  end

  // Watchdog: counts edges where neither stream moves a word.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] pick_pressure();
    // extremes now and then, otherwise any value
    if ($urandom_range(7) == 0)
      return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    return SAMPLE_BITS'($urandom());
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_volume();
    if ($urandom_range(7) == 0)
      return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return SAMPLE_BITS'($urandom());
  endfunction

  // Present one sample; valid only drops while idling, never around a handshake.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] p,
                             input logic [SAMPLE_BITS-1:0] v, input bit mark);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, p};
    s_axis_tlast  <= mark;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_sample(p, v, mark);
  endtask

  // Wait for every expected word, then let a trailing plain sample finish.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_WORK_GAIN)
      board.gain = data[GAIN_W-1:0];
    @(posedge clk_i);
  endtask

  // Read the gain back and compare with the scoreboard's copy.
  task automatic check_gain();
    logic [APB_DATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_WORK_GAIN;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== APB_DATA_W'(board.gain))
      board.report($sformatf("work_gain read %0h, want %0h", got, board.gain));
    @(posedge clk_i);
  endtask

  task automatic set_gain(input logic [GAIN_W-1:0] g);
    drain();
    apb_write(ADDR_WORK_GAIN, APB_DATA_W'(g));
    check_gain();
  endtask

  // One loop that circles the full sample box many times. Upward winding
  // piles up positive terms, the other way negative ones.
  task automatic wind_box(input int rounds, input bit upward);
    logic signed [SAMPLE_BITS-1:0] cp [4];
    logic [SAMPLE_BITS-1:0]        cv [4];
    int                            k;
    cp = '{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF};
    cv = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF};
    if (!upward) begin
      cp[1] = 16'sh7FFF;
      cv[1] = 16'hFFFF;
      cp[3] = 16'sh8000;
      cv[3] = 16'h0000;
    end
    send_sample(cp[0], cv[0], 1'b1);
    for (k = 1; k < rounds * 4; k++)
      send_sample(cp[k % 4], cv[k % 4], 1'b0);
    send_sample(cp[0], cv[0], 1'b1);
  endtask

  initial begin
    logic [GAIN_W-1:0] gains [5];
    int                sent, n, ph;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // gain after reset, then a write to the empty slot must leave it alone
    check_gain();
    apb_write(ADDR_SPARE, $urandom());
    check_gain();

    // --- directed ---
    // samples before any beat are dropped
    send_sample(16'sd100, 16'd200, 1'b0);
    send_sample(16'sh8000, 16'hFFFF, 1'b0);
    // first beat has no loop to close: all-zero word
    send_sample(16'sd0, 16'd0, 1'b1);
    // box corners at the field extremes
    send_sample(16'sh7FFF, 16'hFFFF, 1'b0);
    send_sample(16'sh8000, 16'hFFFF, 1'b0);
    send_sample(16'sh8000, 16'h0000, 1'b0);
    send_sample(16'sh7FFF, 16'h0000, 1'b1);
    // back-to-back beats: one-vertex loop, zero area
    send_sample(16'sh7FFF, 16'h0000, 1'b1);
    send_sample(-16'sd1, 16'd1, 1'b0);
    send_sample(16'sd1, 16'hFFFE, 1'b0);
    send_sample(16'sd12345, 16'd40000, 1'b0);
    send_sample(16'sh8000, 16'hFFFF, 1'b1);
    send_sample(16'sh7FFF, 16'hFFFF, 1'b0);
    send_sample(16'sh8000, 16'h0000, 1'b0);
    send_sample(-16'sd7, 16'h8000, 1'b1);

    // --- large areas of both signs at full gain ---
    set_gain(16'hFFFF);
    idle_pct = 0;          // long stretch with no idling on either side
    wind_box(WIND_ROUNDS, 1'b1);
    drain();
    idle_pct = 13;
    wind_box(WIND_ROUNDS, 1'b0);

    // --- random loops under several gains ---
    gains = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, GAIN_W'($urandom())};
    for (ph = 0; ph < 5; ph++) begin
      set_gain(gains[ph]);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        if ($urandom_range(9) == 0) begin
          // noise: marks at random, loops of any length including none
          n = $urandom_range(1, 6);
          repeat (n) begin
            send_sample(pick_pressure(), pick_volume(), 1'($urandom_range(1)));
            sent++;
          end
        end else begin
          // well-formed loop: a beat then a few plain samples
          send_sample(pick_pressure(), pick_volume(), 1'b1);
          sent++;
          n = $urandom_range(0, 12);
          repeat (n) begin
            send_sample(pick_pressure(), pick_volume(), 1'b0);
            sent++;
          end
        end
      end
    end
    // close the last loop so its word is checked too
    send_sample(pick_pressure(), pick_volume(), 1'b1);

    drain();
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
